FILE: hdl/spq_pkg.sv
// Package with the command and status codes and shared types of the sorted priority queue.
package spq_pkg;

    // Fixed field widths.
    localparam int PRIO_BITS   = 32;
    localparam int TAG_W       = 16;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 104;

    // Command codes carried in the slave-side tuser.
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // Status codes carried in the master-side tuser.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Per-cycle shift control that every cell of the chain sees.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

FILE: hdl/spq_cell.sv
// One cell of the sorted chain: holds a single entry and shifts it to or from its neighbors.
module spq_cell #(
    parameter int TAG_BITS = 16
) (
    input  logic                          i_clk,
    input  spq_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_occupied,
    input  logic                          i_left_lt,
    input  logic signed [31:0]            i_new_prio,
    input  logic [TAG_BITS-1:0]           i_new_tag,
    input  logic signed [31:0]            i_left_prio,
    input  logic [TAG_BITS-1:0]           i_left_tag,
    input  logic signed [31:0]            i_right_prio,
    input  logic [TAG_BITS-1:0]           i_right_tag,
    output logic                          o_lt,
    output logic signed [31:0]            o_prio,
    output logic [TAG_BITS-1:0]           o_tag,
    output logic signed [31:0]            o_next_prio,
    output logic [TAG_BITS-1:0]           o_next_tag
);
    import spq_pkg::*;

    logic signed [PRIO_BITS-1:0] r_prio, n_prio;
    logic [TAG_BITS-1:0]         r_tag, n_tag;

    // An occupied cell whose priority is below the new one keeps its place on an enqueue.
    assign o_lt = i_occupied && (r_prio < i_new_prio);

    // Next entry: hold, take the new entry, take the left neighbor, or take the right one.
    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctrl.enq) begin
            if (!i_left_lt) begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end else if (!o_lt) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end
        end else if (i_ctrl.deq) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    // Entry storage; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio      = r_prio;
    assign o_tag       = r_tag;
    assign o_next_prio = n_prio;
    assign o_next_tag  = n_tag;

endmodule

FILE: hdl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a shifting chain of entry cells with a result register.
//
//  Channel   Direction  tdata (low bit up)                                tuser
//  s_axis    in         priority_req[31:0], tag[47:32]                    cmd[1:0]
//  m_axis    out        removed_priority[31:0], removed_tag[47:32],        status[1:0]
//                       head_valid[48], head_priority[80:49],
//                       head_tag[96:81], count[103:97]
//
//  Each operation's result appears in the output register on the next cycle after it is
//  accepted; one operation per cycle is sustained while the result side takes them.
//  Every cell compares its entry with the new priority in parallel and the chain shifts
//  in that same cycle, so the cost of an operation does not depend on the fill level.
//  Reset clears the count and the result valid flag; the entries need no reset.
//  When a result waits untaken, the input stalls until that transaction completes.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [spq_pkg::S_DATA_W-1:0] i_s_tdata,  // priority_req, tag
    input  logic [spq_pkg::CMD_W-1:0]    i_s_tuser,  // cmd
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [spq_pkg::M_DATA_W-1:0] o_m_tdata,  // removed_priority, removed_tag,
                                                     // head_valid, head_priority,
                                                     // head_tag, count
    output logic [spq_pkg::STATUS_W-1:0] o_m_tuser   // status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Input unpacking.
    logic                        accept;
    logic [CMD_W-1:0]            cmd;
    logic signed [PRIO_BITS-1:0] new_prio;
    logic [TAG_W-1:0]            tag_in;
    logic [TAG_BITS+TAG_W-1:0]   tag_in_wide;
    logic [TAG_BITS-1:0]         new_tag;

    assign cmd         = i_s_tuser;
    assign new_prio    = i_s_tdata[31:0];
    assign tag_in      = i_s_tdata[47:32];
    assign tag_in_wide = {{TAG_BITS{1'b0}}, tag_in};
    assign new_tag     = tag_in_wide[TAG_BITS-1:0];

    // Control state.
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic             full, empty;
    t_cell_ctrl       ctrl;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign ctrl.enq   = accept && (cmd == CMD_ENQUEUE) && !full;
    assign ctrl.deq   = accept && (cmd == CMD_DEQUEUE) && !empty;

    // Cell chain: cell 0 holds the head, priorities rise toward the tail.
    logic signed [PRIO_BITS-1:0] c_prio      [CAPACITY];
    logic [TAG_BITS-1:0]         c_tag       [CAPACITY];
    logic signed [PRIO_BITS-1:0] c_next_prio [CAPACITY];
    logic [TAG_BITS-1:0]         c_next_tag  [CAPACITY];
    logic                        c_lt        [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [PRIO_BITS-1:0] left_prio, right_prio;
        logic [TAG_BITS-1:0]         left_tag, right_tag;
        logic                        left_lt;

        if (k == 0) begin : g_first
            assign left_prio = new_prio;
            assign left_tag  = new_tag;
            assign left_lt   = 1'b1;
        end else begin : g_inner
            assign left_prio = c_prio[k-1];
            assign left_tag  = c_tag[k-1];
            assign left_lt   = c_lt[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_prio = c_prio[k];
            assign right_tag  = c_tag[k];
        end else begin : g_body
            assign right_prio = c_prio[k+1];
            assign right_tag  = c_tag[k+1];
        end

        spq_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_occupied  (CNT_W'(k) < r_count),
            .i_left_lt   (left_lt),
            .i_new_prio  (new_prio),
            .i_new_tag   (new_tag),
            .i_left_prio (left_prio),
            .i_left_tag  (left_tag),
            .i_right_prio(right_prio),
            .i_right_tag (right_tag),
            .o_lt        (c_lt[k]),
            .o_prio      (c_prio[k]),
            .o_tag       (c_tag[k]),
            .o_next_prio (c_next_prio[k]),
            .o_next_tag  (c_next_tag[k])
        );
    end

    // Next count.
    always_comb begin
        n_count = r_count;
        if (ctrl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.deq) begin
            n_count = r_count - CNT_W'(1);
        end else if (accept && (cmd == CMD_CLEAR)) begin
            n_count = '0;
        end
    end

    // Result fields of the accepted transaction.
    logic [STATUS_W-1:0]         res_status;
    logic signed [PRIO_BITS-1:0] res_rem_prio, res_head_prio;
    logic [TAG_W-1:0]            res_rem_tag, res_head_tag;
    logic                        res_head_valid;
    logic [TAG_BITS+TAG_W-1:0]   rem_tag_wide, head_tag_wide;
    logic [CNT_W+COUNT_W-1:0]    count_wide;

    assign rem_tag_wide  = {{TAG_W{1'b0}}, c_tag[0]};
    assign head_tag_wide = {{TAG_W{1'b0}}, c_next_tag[0]};
    assign count_wide    = {{COUNT_W{1'b0}}, n_count};

    always_comb begin
        res_status = STATUS_OK;
        if ((cmd == CMD_ENQUEUE) && full) begin
            res_status = STATUS_FULL;
        end else if ((cmd == CMD_DEQUEUE) && empty) begin
            res_status = STATUS_EMPTY;
        end
        res_rem_prio   = ctrl.deq ? c_prio[0] : '0;
        res_rem_tag    = ctrl.deq ? rem_tag_wide[TAG_W-1:0] : '0;
        res_head_valid = (n_count != '0);
        res_head_prio  = res_head_valid ? c_next_prio[0] : '0;
        res_head_tag   = res_head_valid ? head_tag_wide[TAG_W-1:0] : '0;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register, loaded on every accepted transaction.
    logic [M_DATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {count_wide[COUNT_W-1:0], res_head_tag, res_head_prio,
                           res_head_valid, res_rem_tag, res_rem_prio};
            r_out_user <= res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: hdl/spq_checker.sv
// Port-level checker for the sorted priority queue and its bind to the top level.
module spq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [spq_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [spq_pkg::STATUS_W-1:0] o_m_tuser
);
    import spq_pkg::*;

    // No result is pending right after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Every accepted input transaction shows a result on the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted transaction produced no result");

    // The head flag agrees with the count, and an empty queue shows a zero head.
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[48] == (o_m_tdata[103:97] != '0)) &&
                        (o_m_tdata[48] || (o_m_tdata[96:49] == '0))))
        else $error("head fields disagree with count");

    // A dequeue on an empty queue removes nothing and leaves the count at zero.
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == STATUS_EMPTY)) |->
            ((o_m_tdata[47:0] == '0) && (o_m_tdata[103:97] == '0)))
        else $error("empty dequeue reported data");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);

FILE: tb/tb.sv
// Self-checking testbench for the sorted priority queue unit: directed rows, then random bursts.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int ITEM_GOAL  = 1900;
    localparam int STALL_MAX  = 2000;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_LEN   = 60;
    localparam int CALM_FROM  = 900;
    localparam int CALM_TO    = 1200;

    // The one command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result transaction, fields in the order of the master-side channel.
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PRIO_BITS-1:0] removed_priority;
        logic [TAG_W-1:0]     removed_tag;
        logic                 head_valid;
        logic [PRIO_BITS-1:0] head_priority;
        logic [TAG_W-1:0]     head_tag;
        logic [COUNT_W-1:0]   count;
    } t_queue_result;

    // One directed row: the operation and, where it is obvious, the result typed in.
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_W-1:0]     tag;
        logic                 fixed;
        t_queue_result        want;
    } t_op_row;

    localparam t_queue_result NO_RESULT    = '0;
    localparam t_queue_result EMPTY_DEQUE  =
        {STATUS_EMPTY, 32'd0, 16'd0, 1'b0, 32'd0, 16'd0, 7'd0};
    localparam t_queue_result EMPTY_QUEUE  =
        {STATUS_OK, 32'd0, 16'd0, 1'b0, 32'd0, 16'd0, 7'd0};
    localparam t_queue_result ONE_MAX      =
        {STATUS_OK, 32'd0, 16'd0, 1'b1, 32'h7FFF_FFFF, 16'hFFFF, 7'd1};
    localparam t_queue_result TWO_MIN_HEAD =
        {STATUS_OK, 32'd0, 16'd0, 1'b1, 32'h8000_0000, 16'h0000, 7'd2};

    // Directed rows: empty-queue errors, the unused command, extreme priorities,
    // ties where the newest entry must come out first, and a clear.
    localparam t_op_row DIRECTED_ROWS [20] = '{
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b1, EMPTY_DEQUE},
        {CMD_UNUSED,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, EMPTY_QUEUE},
        {CMD_CLEAR,   32'h0000_0000, 16'h0000, 1'b1, EMPTY_QUEUE},
        {CMD_ENQUEUE, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, ONE_MAX},
        {CMD_ENQUEUE, 32'h8000_0000, 16'h0000, 1'b1, TWO_MIN_HEAD},
        {CMD_ENQUEUE, 32'h8000_0000, 16'h1234, 1'b0, NO_RESULT},
        {CMD_ENQUEUE, 32'h0000_0000, 16'hAAAA, 1'b0, NO_RESULT},
        {CMD_ENQUEUE, 32'hFFFF_FFFF, 16'h5555, 1'b0, NO_RESULT},
        {CMD_ENQUEUE, 32'h0000_0000, 16'h0001, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, NO_RESULT},
        {CMD_UNUSED,  32'h5A5A_5A5A, 16'hA5A5, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b0, NO_RESULT},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b1, EMPTY_DEQUE},
        {CMD_ENQUEUE, 32'h0000_0001, 16'h0007, 1'b0, NO_RESULT},
        {CMD_CLEAR,   32'h0000_0000, 16'h0000, 1'b1, EMPTY_QUEUE},
        {CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1'b1, EMPTY_DEQUE}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata  = '0;  // priority_req, tag
    logic [CMD_W-1:0]      i_s_tuser  = '0;  // cmd
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;        // removed_priority, removed_tag, head_valid,
                                             // head_priority, head_tag, count
    logic [STATUS_W-1:0]   o_m_tuser;        // status

    // Shadow copy of the queue contents; slot 0 holds the highest priority.
    logic signed [PRIO_BITS-1:0] held_prio [CAPACITY];
    logic [TAG_W-1:0]            held_tag  [CAPACITY];
    int                          held_count = 0;

    t_queue_result awaited_results [$];
    int            errors        = 0;
    int            items_sent    = 0;
    int            accepted_ops  = 0;
    int            results_seen  = 0;
    int            stall_cycles  = 0;

    sorted_priority_queue_unit #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one operation to the shadow queue and return the result it must produce.
    function automatic t_queue_result predict_queue_op(logic [CMD_W-1:0] op,
                                                       logic signed [PRIO_BITS-1:0] prio,
                                                       logic [TAG_W-1:0] tag);
        t_queue_result r;
        int            i;
        r = '0;
        case (op)
            CMD_ENQUEUE: begin
                if (held_count >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    // Walk down from the head past every strictly lower priority.
                    i = held_count;
                    while (i > 0 && held_prio[i-1] < prio) begin
                        held_prio[i] = held_prio[i-1];
                        held_tag[i]  = held_tag[i-1];
                        i--;
                    end
                    held_prio[i] = prio;
                    held_tag[i]  = tag;
                    held_count++;
                end
            end
            CMD_DEQUEUE: begin
                if (held_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    held_count--;
                    r.removed_priority = held_prio[held_count];
                    r.removed_tag      = held_tag[held_count];
                end
            end
            CMD_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        if (held_count > 0) begin
            r.head_valid    = 1'b1;
            r.head_priority = held_prio[held_count-1];
            r.head_tag      = held_tag[held_count-1];
        end
        r.count = 7'(held_count);
        return r;
    endfunction

    // Priorities that favor ties and extremes over the whole range.
    function automatic logic [PRIO_BITS-1:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return 32'($urandom_range(16)) - 32'd8;
        if (sel < 55) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one operation, wait for its transaction, then record the expected result.
    task automatic offer_op(input logic [CMD_W-1:0] op, input logic [PRIO_BITS-1:0] prio,
                            input logic [TAG_W-1:0] tag, input logic fixed,
                            input t_queue_result want);
        t_queue_result predicted;
        while (!(accepted_ops >= CALM_FROM && accepted_ops < CALM_TO)
               && $urandom_range(99) < 22) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tag, prio};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_queue_op(op, prio, tag);
        awaited_results.push_back(fixed ? want : predicted);
        accepted_ops++;
        if (op != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic random_op(input int enq_percent);
        if ($urandom_range(99) < enq_percent)
            offer_op(CMD_ENQUEUE, pick_priority(), 16'($urandom_range(65535)), 1'b0,
                     NO_RESULT);
        else
            offer_op(CMD_DEQUEUE, $urandom, 16'($urandom_range(65535)), 1'b0, NO_RESULT);
    endtask

    // Hold the sender until every result in flight has been taken.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Result side: compare each transaction with the oldest expectation, then pick tready.
    initial begin : result_side
        t_queue_result got;
        t_queue_result want;
        int            hold_left;
        bit            hold_done;
        hold_left = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_m_tvalid && i_m_tready) begin
                    got = {o_m_tuser, o_m_tdata[31:0], o_m_tdata[47:32], o_m_tdata[48],
                           o_m_tdata[80:49], o_m_tdata[96:81], o_m_tdata[103:97]};
                    results_seen++;
                    if (awaited_results.size() == 0) begin
                        errors++;
                        $display("%0t ns: unexpected result, expected none, got %h",
                                 $time, got);
                    end else begin
                        want = awaited_results.pop_front();
                        check_field("status", 32'(want.status), 32'(got.status));
                        check_field("removed_priority", want.removed_priority,
                                    got.removed_priority);
                        check_field("removed_tag", 32'(want.removed_tag),
                                    32'(got.removed_tag));
                        check_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                        check_field("head_priority", want.head_priority, got.head_priority);
                        check_field("head_tag", 32'(want.head_tag), 32'(got.head_tag));
                        check_field("count", 32'(want.count), 32'(got.count));
                    end
                end
                // One long hold-off lets the block fill up and stall its input.
                if (hold_left > 0) begin
                    hold_left--;
                    i_m_tready <= 1'b0;
                end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                    hold_done = 1;
                    hold_left = HOLD_LEN - 1;
                    i_m_tready <= 1'b0;
                end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= ($urandom_range(99) >= 22);
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no transaction on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus: reset, directed rows, then random bursts.
    initial begin : stimulus
        int sel;
        int margin;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[n])
            offer_op(DIRECTED_ROWS[n].cmd, DIRECTED_ROWS[n].prio, DIRECTED_ROWS[n].tag,
                     DIRECTED_ROWS[n].fixed, DIRECTED_ROWS[n].want);
        wait_for_results();

        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(9) == 0)
                wait_for_results();
            sel = $urandom_range(99);
            if (sel < 20) begin
                // Fill to capacity and push a few enqueues past it.
                margin = $urandom_range(1, 4);
                while (margin > 0) begin
                    if (held_count == CAPACITY)
                        margin--;
                    random_op(90);
                end
            end else if (sel < 40) begin
                // Drain the queue and dequeue a few times while it is empty.
                margin = $urandom_range(1, 3);
                while (margin > 0) begin
                    if (held_count == 0)
                        margin--;
                    random_op(10);
                end
            end else if (sel < 85) begin
                repeat ($urandom_range(10, 40)) begin
                    if ($urandom_range(99) < 3)
                        offer_op(CMD_CLEAR, $urandom, 16'($urandom_range(65535)), 1'b0,
                                 NO_RESULT);
                    else
                        random_op(50);
                end
            end else if (sel < 92) begin
                offer_op(CMD_CLEAR, $urandom, 16'($urandom_range(65535)), 1'b0, NO_RESULT);
            end else begin
                repeat ($urandom_range(1, 3))
                    offer_op(CMD_UNUSED, $urandom, 16'($urandom_range(65535)), 1'b0,
                             NO_RESULT);
            end
        end

        // Let every result drain, then watch for stray ones.
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
hdl/spq_checker.sv
tb/tb.sv
